// File: rtl/case_insensitive_substring_search_core_assert.svh
// Assertion macros used by the substring search RTL.
`ifndef CASE_INSENSITIVE_SUBSTRING_SEARCH_CORE_ASSERT_SVH
`define CASE_INSENSITIVE_SUBSTRING_SEARCH_CORE_ASSERT_SVH

// Checks a consequent in the same cycle as its antecedent.
`define CISSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequent in the cycle after its antecedent.
`define CISSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cisss_pkg.sv
// Types, constants and helper functions of the substring search core.
package cisss_pkg;

  localparam int CISSS_MAX_PATTERN = 16;
  localparam int CFG_INDEX_W       = 2;
  localparam int CFG_DATA_W        = 64;
  localparam int LINE_W            = 32;
  localparam int COLUMN_W          = 16;
  localparam int LENGTH_W          = 5;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW,
    REG_PATTERN_HIGH,
    REG_PATTERN_LENGTH
  } cfg_reg_t;

  typedef struct packed {
    logic                hit;
    logic [LINE_W-1:0]   line;
    logic [COLUMN_W-1:0] column;
  } hit_t;

  // Maps ASCII upper case letters onto lower case; other bytes pass unchanged.
  function automatic logic [7:0] fold(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'd65 && b <= 8'd90) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

endpackage

// File: rtl/cisss_if.sv
// Handshake interfaces for the text, result and configuration channels.
interface cisss_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source(output valid, text_byte, end_of_text, input ready);
  modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

interface cisss_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] match_line;
  logic [15:0] match_column;

  modport source(output valid, match_line, match_column, input ready);
  modport sink(input valid, match_line, match_column, output ready);
endinterface

interface cisss_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [63:0] reg_data;

  modport source(output valid, reg_index, reg_data, input ready);
  modport sink(input valid, reg_index, reg_data, output ready);
endinterface

// File: rtl/cisss_cfg_regs.sv
// Pattern registers and the length-aligned, case-folded pattern they imply.
module cisss_cfg_regs
  import cisss_pkg::*;
#(
  parameter int MAX_PATTERN = CISSS_MAX_PATTERN,
  parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  cisss_cfg_if.sink                cfg,
  output logic [LEN_W-1:0]         eff_len,
  output logic [MAX_PATTERN-1:0]   len_mask,
  output logic [8*MAX_PATTERN-1:0] aligned_pat
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [LENGTH_W-1:0]   pattern_length;
  logic [31:0]           length_ext;
  logic [7:0]            pat [MAX_PATTERN];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= LENGTH_W'(1);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.reg_index))
        REG_PATTERN_LOW:    pattern_low    <= cfg.reg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg.reg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg.reg_data[LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero length acts as one; lengths beyond the window are clamped.
  assign length_ext = {{(32-LENGTH_W){1'b0}}, pattern_length};

  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (length_ext > 32'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = LEN_W'(length_ext);
    end
  end

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pat
    if (i < 8) begin : g_low
      assign pat[i] = pattern_low[8*i +: 8];
    end else if (i < 16) begin : g_high
      assign pat[i] = pattern_high[8*(i-8) +: 8];
    end else begin : g_zero
      assign pat[i] = 8'h00;
    end
  end

  // Window position k holds the byte received k beats ago, so it lines up with
  // pattern byte (length - 1 - k).
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_align
    logic [LEN_W-1:0] src_idx;
    assign src_idx     = eff_len - LEN_W'(k) - LEN_W'(1);
    assign len_mask[k] = eff_len > LEN_W'(k);
    assign aligned_pat[8*k +: 8] = len_mask[k] ? fold(pat[src_idx[IDX_W-1:0]]) : 8'h00;
  end

endmodule

// File: rtl/cisss_scan.sv
// Byte window, line and column counters, and the parallel window compare.
`include "case_insensitive_substring_search_core_assert.svh"

module cisss_scan
  import cisss_pkg::*;
#(
  parameter int MAX_PATTERN = CISSS_MAX_PATTERN,
  parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic [7:0]               text_byte,
  input  logic                     end_of_text,
  input  logic [LEN_W-1:0]         eff_len,
  input  logic [MAX_PATTERN-1:0]   len_mask,
  input  logic [8*MAX_PATTERN-1:0] aligned_pat,
  output hit_t                     res
);

  logic [7:0]          window [MAX_PATTERN];
  logic [7:0]          win_new [MAX_PATTERN];
  logic [LEN_W-1:0]    window_fill;
  logic [LEN_W-1:0]    suppress_count;
  logic [LINE_W-1:0]   line_count;
  logic [COLUMN_W-1:0] column_count;

  logic [LEN_W-1:0]    fill_inc;
  logic [COLUMN_W-1:0] column_inc;
  logic [MAX_PATTERN-1:0] eq;
  logic                line_end;

  logic [LEN_W-1:0]    window_fill_next;
  logic [LEN_W-1:0]    suppress_count_next;
  logic [LINE_W-1:0]   line_count_next;
  logic [COLUMN_W-1:0] column_count_next;

  assign win_new[0] = text_byte;
  for (genvar k = 1; k < MAX_PATTERN; k++) begin : g_shift
    assign win_new[k] = window[k-1];
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cmp
    assign eq[k] = fold(win_new[k]) == aligned_pat[8*k +: 8];
  end

  assign fill_inc   = (window_fill < LEN_W'(MAX_PATTERN)) ? window_fill + LEN_W'(1)
                                                          : window_fill;
  assign column_inc = (column_count != '1) ? column_count + COLUMN_W'(1) : column_count;
  assign line_end   = (text_byte == NEWLINE_BYTE) || end_of_text;

  assign res.hit    = (suppress_count == '0) && (fill_inc >= eff_len) && (&(eq | ~len_mask));
  assign res.line   = line_count;
  assign res.column = column_inc - COLUMN_W'(eff_len) + COLUMN_W'(1);

  always_comb begin
    window_fill_next    = fill_inc;
    column_count_next   = column_inc;
    line_count_next     = line_count;
    suppress_count_next = suppress_count;
    if (suppress_count != '0) begin
      suppress_count_next = suppress_count - LEN_W'(1);
    end else if (res.hit) begin
      suppress_count_next = eff_len - LEN_W'(1);
    end
    if (text_byte == NEWLINE_BYTE) begin
      window_fill_next    = '0;
      suppress_count_next = '0;
      column_count_next   = '0;
      if (line_count != '1) begin
        line_count_next = line_count + LINE_W'(1);
      end
    end
    if (end_of_text) begin
      window_fill_next    = '0;
      suppress_count_next = '0;
      column_count_next   = '0;
      line_count_next     = LINE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill    <= '0;
      suppress_count <= '0;
      line_count     <= LINE_W'(1);
      column_count   <= '0;
    end else if (advance) begin
      window_fill    <= window_fill_next;
      suppress_count <= suppress_count_next;
      line_count     <= line_count_next;
      column_count   <= column_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      window <= win_new;
    end
  end

  `CISSS_ASSERT_NOW(a_hit_outside_suppression, advance && res.hit, suppress_count == '0, "hit reported while suppression active")
  `CISSS_ASSERT_NEXT(a_suppress_loaded, advance && res.hit && !line_end, suppress_count == $past(eff_len) - LEN_W'(1), "suppression span not loaded after hit")
  `CISSS_ASSERT_NOW(a_fill_bounded, 1'b1, window_fill <= LEN_W'(MAX_PATTERN), "window fill beyond window depth")
  `CISSS_ASSERT_NEXT(a_eot_restarts, advance && end_of_text, line_count == LINE_W'(1) && column_count == '0 && window_fill == '0, "counters not restarted after end of text")

endmodule

// File: rtl/case_insensitive_substring_search_core.sv
// Case-insensitive substring search core: takes one text byte per beat and
// reports each non-overlapping pattern hit with its line and starting column.
// The core accepts a byte on every clock cycle unless input stalls; the hit
// for a byte is shown on the result channel in the cycle after the byte is
// accepted. This follows from the combinational compare of the whole byte
// window against the configured pattern, followed by one output register.
// Input stalls only when that output register holds a result not yet taken.
// There is no clearing pass after reset; the block is ready at once.
module case_insensitive_substring_search_core
  import cisss_pkg::*;
#(
  parameter int MAX_PATTERN = CISSS_MAX_PATTERN
) (
  input  logic          clk,
  input  logic          rst,
  cisss_text_if.sink    text,
  cisss_result_if.source result,
  cisss_cfg_if.sink     cfg
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [LEN_W-1:0]         eff_len;
  logic [MAX_PATTERN-1:0]   len_mask;
  logic [8*MAX_PATTERN-1:0] aligned_pat;
  hit_t                     res;
  logic                     advance;

  logic                     out_valid;
  logic [LINE_W-1:0]        out_line;
  logic [COLUMN_W-1:0]      out_column;

  cisss_cfg_regs #(
    .MAX_PATTERN(MAX_PATTERN),
    .LEN_W      (LEN_W)
  ) u_cfg_regs (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .eff_len    (eff_len),
    .len_mask   (len_mask),
    .aligned_pat(aligned_pat)
  );

  cisss_scan #(
    .MAX_PATTERN(MAX_PATTERN),
    .LEN_W      (LEN_W)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .text_byte  (text.text_byte),
    .end_of_text(text.end_of_text),
    .eff_len    (eff_len),
    .len_mask   (len_mask),
    .aligned_pat(aligned_pat),
    .res        (res)
  );

  assign text.ready = !out_valid || result.ready;
  assign advance    = text.valid && text.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.hit;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.hit) begin
      out_line   <= res.line;
      out_column <= res.column;
    end
  end

  assign result.valid        = out_valid;
  assign result.match_line   = out_line;
  assign result.match_column = out_column;

endmodule

// File: dv/case_insensitive_substring_search_core_tb.sv
// Self-checking testbench of the case-insensitive substring search core.
module case_insensitive_substring_search_core_tb;
  import cisss_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 2000;
  localparam int MAX_REPORTS = 100;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 90;
  localparam int PRESSURE_PHASE = 7;

  typedef struct packed {
    logic [LINE_W-1:0]   line;
    logic [COLUMN_W-1:0] column;
  } hit_rec_t;

  typedef enum {ROW_BYTE, ROW_REG} row_kind_t;
  typedef enum {CHK_MODEL, CHK_HIT, CHK_NONE} row_check_t;
  typedef enum {PAT_MIXED, PAT_ONES, PAT_ZEROS, PAT_REPEAT} pat_style_t;

  typedef struct {
    row_kind_t           kind;
    logic [1:0]          reg_idx;
    logic [63:0]         reg_data;
    logic [7:0]          text_byte;
    logic                eot;
    row_check_t          chk;
    logic [LINE_W-1:0]   line;
    logic [COLUMN_W-1:0] column;
  } script_row_t;

  logic clk;
  logic rst = 1'b1;

  cisss_text_if   text_ch ();
  cisss_result_if result_ch ();
  cisss_cfg_if    cfg_ch ();

  case_insensitive_substring_search_core i_dut (
    .clk   (clk),
    .rst   (rst),
    .text  (text_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  logic [63:0]         pat_lo;
  logic [63:0]         pat_hi;
  logic [LENGTH_W-1:0] pat_len_reg;
  logic [7:0]          win_bytes [CISSS_MAX_PATTERN];
  logic [4:0]          win_fill;
  logic [3:0]          skip_left;
  logic [LINE_W-1:0]   cur_line;
  logic [COLUMN_W-1:0] cur_col;

  hit_rec_t   pending_hits[$];
  logic [7:0] pat_buf [CISSS_MAX_PATTERN];
  int         errors = 0;
  int         items_sent = 0;
  int         text_gap_max = 7;
  bit         text_burst = 1'b0;
  bit         hold_results = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
  endfunction

  function automatic logic [7:0] random_case(input logic [7:0] b);
    logic [7:0] low;
    low = b | 8'h20;
    if (low >= 8'h61 && low <= 8'h7A && $urandom_range(0, 1) == 1) begin
      return b ^ 8'h20;
    end
    return b;
  endfunction

  function automatic int pattern_span();
    int n;
    n = pat_len_reg;
    if (n == 0) begin
      n = 1;
    end
    if (n > CISSS_MAX_PATTERN) begin
      n = CISSS_MAX_PATTERN;
    end
    return n;
  endfunction

  function automatic void start_line();
    win_fill = '0;
    skip_left = '0;
    cur_col = '0;
  endfunction

  function automatic void search_step(input logic [7:0] b, input logic eot,
                                      output logic hit, output hit_rec_t rec);
    int n;
    int i;
    logic [127:0] pat;
    logic same;
    n = pattern_span();
    pat = {pat_hi, pat_lo};
    hit = 1'b0;
    rec = '0;
    for (i = CISSS_MAX_PATTERN - 1; i > 0; i--) begin
      win_bytes[i] = win_bytes[i-1];
    end
    win_bytes[0] = b;
    if (win_fill < CISSS_MAX_PATTERN) begin
      win_fill++;
    end
    if (cur_col != '1) begin
      cur_col++;
    end
    if (skip_left != 0) begin
      skip_left--;
    end else if (win_fill >= n) begin
      same = 1'b1;
      for (i = 0; i < n; i++) begin
        if (to_lower(pat[8*i +: 8]) != to_lower(win_bytes[n-1-i])) begin
          same = 1'b0;
        end
      end
      if (same) begin
        hit = 1'b1;
        rec.line = cur_line;
        rec.column = cur_col - 16'(n) + 16'd1;
        skip_left = 4'(n - 1);
      end
    end
    if (b == NEWLINE_BYTE) begin
      start_line();
      if (cur_line != '1) begin
        cur_line++;
      end
    end
    if (eot) begin
      start_line();
      cur_line = 1;
    end
  endfunction

  function automatic script_row_t byte_row(input logic [7:0] b, input logic eot,
                                           input row_check_t chk,
                                           input logic [LINE_W-1:0] line = '0,
                                           input logic [COLUMN_W-1:0] column = '0);
    script_row_t row;
    row = '{ROW_BYTE, '0, '0, b, eot, chk, line, column};
    return row;
  endfunction

  function automatic script_row_t reg_row(input logic [1:0] idx, input logic [63:0] data);
    script_row_t row;
    row = '{ROW_REG, idx, data, '0, 1'b0, CHK_NONE, '0, '0};
    return row;
  endfunction

  function automatic logic [7:0] pick_byte(input int n);
    int r;
    logic [7:0] edges [8];
    edges = '{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};
    r = $urandom_range(0, 99);
    if (r < 35) begin
      return random_case(pat_buf[$urandom_range(0, n - 1)]);
    end else if (r < 45) begin
      return NEWLINE_BYTE;
    end else if (r < 55) begin
      return edges[$urandom_range(0, 7)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void fill_pattern(input pat_style_t style);
    int i;
    int r;
    logic [7:0] letter;
    letter = 8'h61 + 8'($urandom_range(0, 25));
    for (i = 0; i < CISSS_MAX_PATTERN; i++) begin
      r = $urandom_range(0, 99);
      case (style)
        PAT_ONES:   pat_buf[i] = 8'hFF;
        PAT_ZEROS:  pat_buf[i] = 8'h00;
        PAT_REPEAT: pat_buf[i] = random_case(letter);
        default: begin
          if (r < 55) begin
            pat_buf[i] = random_case(8'h61 + 8'($urandom_range(0, 25)));
          end else if (r < 62) begin
            pat_buf[i] = NEWLINE_BYTE;
          end else if (r < 72) begin
            pat_buf[i] = pick_byte(1);
          end else begin
            pat_buf[i] = 8'($urandom_range(0, 255));
          end
        end
      endcase
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eot, input row_check_t chk,
                           input logic [LINE_W-1:0] line, input logic [COLUMN_W-1:0] column);
    int gap;
    logic hit;
    hit_rec_t rec;
    if ($urandom_range(0, 63) == 0) begin
      text_burst = !text_burst;
    end
    gap = text_burst ? 0 : $urandom_range(0, text_gap_max);
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.text_byte <= b;
    text_ch.end_of_text <= eot;
    do @(posedge clk); while (!text_ch.ready);
    search_step(b, eot, hit, rec);
    case (chk)
      CHK_MODEL: begin
        if (hit) begin
          pending_hits.push_back(rec);
        end
      end
      CHK_HIT: pending_hits.push_back('{line, column});
      default: ;
    endcase
  endtask

  task automatic send_text(input logic [7:0] b);
    send_byte(b, $urandom_range(0, 39) == 0, CHK_MODEL, '0, '0);
    items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    text_ch.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.reg_data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_PATTERN_LOW:    pat_lo = data;
      REG_PATTERN_HIGH:   pat_hi = data;
      REG_PATTERN_LENGTH: pat_len_reg = data[LENGTH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_pattern(input logic [LENGTH_W-1:0] len);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] len_word;
    int i;
    for (i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pat_buf[i];
      hi[8*i +: 8] = pat_buf[i+8];
    end
    len_word = {$urandom, $urandom};
    len_word[LENGTH_W-1:0] = len;
    if ($urandom_range(0, 2) == 0) begin
      write_reg(REG_SPARE, {$urandom, $urandom});
    end
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LENGTH, len_word);
  endtask

  initial begin : result_sink
    int gap;
    bit burst;
    burst = 1'b0;
    result_ch.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_results) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) begin
        burst = !burst;
      end
      gap = burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  always @(posedge clk) begin : check_hits
    hit_rec_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_hits.size() == 0) begin
        if (errors < MAX_REPORTS) begin
          $display("%0t: unexpected hit, expected none, actual line %0d column %0d",
                   $time, result_ch.match_line, result_ch.match_column);
        end
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (result_ch.match_line !== want.line) begin
          if (errors < MAX_REPORTS) begin
            $display("%0t: match_line mismatch, expected %0d, actual %0d",
                     $time, want.line, result_ch.match_line);
          end
          errors++;
        end
        if (result_ch.match_column !== want.column) begin
          if (errors < MAX_REPORTS) begin
            $display("%0t: match_column mismatch, expected %0d, actual %0d",
                     $time, want.column, result_ch.match_column);
          end
          errors++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    script_row_t script[$];
    logic [LENGTH_W-1:0] len;
    int i;
    int k;
    int n;
    int r;
    int reps;
    int cut;
    int phase;
    int phase_end;
    int drain;

    text_ch.valid = 1'b0;
    text_ch.text_byte = '0;
    text_ch.end_of_text = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.reg_data = '0;
    pat_lo = '0;
    pat_hi = '0;
    pat_len_reg = 5'd1;
    for (i = 0; i < CISSS_MAX_PATTERN; i++) begin
      win_bytes[i] = '0;
    end
    start_line();
    cur_line = 1;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // The reset pattern is a single zero byte, so zero text bytes hit at once.
    script.push_back(byte_row(8'h00, 1'b0, CHK_HIT, 1, 1));
    script.push_back(byte_row(8'hFF, 1'b0, CHK_NONE));
    script.push_back(byte_row(NEWLINE_BYTE, 1'b0, CHK_NONE));
    script.push_back(byte_row(8'h00, 1'b1, CHK_HIT, 2, 1));
    script.push_back(byte_row(8'h00, 1'b0, CHK_HIT, 1, 1));
    script.push_back(reg_row(REG_PATTERN_LOW, 64'h6241));
    script.push_back(reg_row(REG_PATTERN_HIGH, '1));
    script.push_back(reg_row(REG_PATTERN_LENGTH, 64'd2));
    script.push_back(reg_row(REG_SPARE, '1));
    script.push_back(byte_row(8'h61, 1'b0, CHK_MODEL));
    script.push_back(byte_row(8'h42, 1'b0, CHK_MODEL));
    script.push_back(byte_row(8'h41, 1'b0, CHK_MODEL));
    script.push_back(byte_row(8'h62, 1'b0, CHK_MODEL));
    script.push_back(byte_row(8'h40, 1'b0, CHK_MODEL));
    script.push_back(reg_row(REG_PATTERN_LENGTH, 64'd0));
    script.push_back(byte_row(8'h61, 1'b0, CHK_MODEL));
    script.push_back(byte_row(8'h60, 1'b0, CHK_MODEL));
    script.push_back(byte_row(8'h5B, 1'b0, CHK_MODEL));
    script.push_back(reg_row(REG_PATTERN_LOW, 64'h0A78));
    script.push_back(reg_row(REG_PATTERN_LENGTH, 64'd2));
    script.push_back(byte_row(8'h58, 1'b0, CHK_MODEL));
    script.push_back(byte_row(NEWLINE_BYTE, 1'b0, CHK_MODEL));
    script.push_back(reg_row(REG_PATTERN_LOW, 64'h780A));
    script.push_back(byte_row(NEWLINE_BYTE, 1'b0, CHK_NONE));
    script.push_back(byte_row(8'h78, 1'b0, CHK_NONE));
    script.push_back(reg_row(REG_PATTERN_LENGTH, 64'd31));
    script.push_back(byte_row(8'hFF, 1'b1, CHK_NONE));

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        write_reg(script[i].reg_idx, script[i].reg_data);
      end else begin
        send_byte(script[i].text_byte, script[i].eot, script[i].chk,
                  script[i].line, script[i].column);
      end
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == PRESSURE_PHASE) begin
        // Every byte hits while the result side stalls, so the core must back up.
        pat_buf[0] = 8'h61;
        load_pattern(5'd1);
        hold_results = 1'b1;
        repeat (40) send_text(random_case(8'h61));
      end
      case (phase)
        0: begin
          fill_pattern(PAT_MIXED);
          len = 5'd1;
        end
        1: begin
          fill_pattern(PAT_MIXED);
          len = 5'd16;
        end
        2: begin
          fill_pattern(PAT_MIXED);
          len = 5'd0;
        end
        3: begin
          fill_pattern(PAT_MIXED);
          len = 5'd31;
        end
        4: begin
          fill_pattern(PAT_ONES);
          len = 5'd17;
        end
        5: begin
          fill_pattern(PAT_ZEROS);
          len = 5'($urandom_range(1, 16));
        end
        6: begin
          fill_pattern(PAT_REPEAT);
          len = 5'($urandom_range(2, 6));
        end
        default: begin
          fill_pattern(PAT_MIXED);
          len = ($urandom_range(0, 1) == 1) ? 5'($urandom_range(1, 4))
                                            : 5'($urandom_range(0, 31));
        end
      endcase
      load_pattern(len);
      n = pattern_span();
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          reps = $urandom_range(1, 3);
          repeat (reps) begin
            for (k = 0; k < n; k++) begin
              send_text(random_case(pat_buf[k]));
            end
          end
        end else if (r < 62) begin
          cut = $urandom_range(0, n - 1);
          for (k = 0; k < cut; k++) begin
            send_text(random_case(pat_buf[k]));
          end
          send_text(pick_byte(n));
        end else begin
          send_text(pick_byte(n));
        end
      end
    end

    text_ch.valid <= 1'b0;
    drain = 0;
    while (pending_hits.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_hits.size() != 0) begin
      $display("%0t: %0d expected hits never arrived", $time, pending_hits.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
